### hdl/circular_queue_search_replace_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the circular queue search and replace unit
// Concurrent assertion wrappers; they compile to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_SEARCH_REPLACE_UNIT_MACROS_SVH
`define CIRCULAR_QUEUE_SEARCH_REPLACE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define CQSR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cqsr assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define CQSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cqsr assertion failed");
`else
`define CQSR_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define CQSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hdl/cqsr_pkg.sv
// ---------------------------------------------------------------------------
// cqsr_pkg
// Shared constants, types and pointer helpers of the circular queue unit.
// ---------------------------------------------------------------------------
package cqsr_pkg;

    // Number of slots in the ring.
    localparam int DEPTH = 16;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 8;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] data_t;

    // Request codes.
    localparam logic [2:0] FUNC_PUSH     = 3'd0;
    localparam logic [2:0] FUNC_POP      = 3'd1;
    localparam logic [2:0] FUNC_RENAME   = 3'd2;
    localparam logic [2:0] FUNC_LIST_FWD = 3'd3;
    localparam logic [2:0] FUNC_LIST_BWD = 3'd4;

    // Result status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_LIST
    } state_t;

    // Memory access request from the sequencer.
    typedef struct packed {
        logic  we;
        ptr_t  waddr;
        data_t wdata;
        ptr_t  raddr;
    } ram_req_t;

    // Status of the sequencer seen by the top level.
    typedef struct packed {
        logic busy;
        cnt_t occupancy;
    } cqsr_stat_t;

    // Slot after p, wrapping at the end of the ring.
    function automatic ptr_t next_slot(input ptr_t p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Slot before p, wrapping at the start of the ring.
    function automatic ptr_t prev_slot(input ptr_t p);
        return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
    endfunction

endpackage

### hdl/circular_queue_search_replace_unit.sv
// ---------------------------------------------------------------------------
// circular_queue_search_replace_unit
// Ring buffer queue with push, pop, rename and two-way listing.
// ---------------------------------------------------------------------------
// Usage:
//   A request (func, entry_value, new_value) is taken on a clock edge where
//   start is high and busy is low. Results appear on out_value, status and
//   last for one cycle each, marked by result_valid; the receiver must take
//   them as they come, there is no way to hold them off.
//   Push: one result in the cycle after the request; busy never rises, so a
//   new request can follow on the next edge.
//   Pop: busy for one cycle while the head entry is read from the memory;
//   the result passes the memory's read register, then the result register.
//   Rename: reads one entry per cycle from head toward tail, busy until a
//   match is replaced or all entries, up to the ring depth (16), are read.
//   Lists: one result per cycle for each stored entry, busy until the last
//   one is sent, so up to 16 results per request.
//   A pop, rename or list on an empty queue, or a push on a full one, ends
//   with one status result in the cycle after. Unused codes give no result.
//   Reset empties the queue at once; the entry memory itself is not cleared.
// ---------------------------------------------------------------------------
`include "circular_queue_search_replace_unit_macros.svh"

module circular_queue_search_replace_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           func,
    input  cqsr_pkg::data_t      entry_value,
    input  cqsr_pkg::data_t      new_value,
    output logic                 result_valid,
    output cqsr_pkg::data_t      out_value,
    output logic [1:0]           status,
    output logic                 last
);
    import cqsr_pkg::*;

    ram_req_t   ram_req;
    data_t      ram_rdata;
    cqsr_stat_t ctrl_stat;

    // Entry memory.
    cqsr_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // Request sequencer.
    cqsr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .func         (func),
        .entry_value  (entry_value),
        .new_value    (new_value),
        .rdata        (ram_rdata),
        .req          (ram_req),
        .stat         (ctrl_stat),
        .result_valid (result_valid),
        .out_value    (out_value),
        .status       (status),
        .last         (last)
    );

    assign busy = ctrl_stat.busy;

    // An accepted push always answers on the next cycle.
    `CQSR_ASSERT_NEXT(a_push_answers, clk, rst_n, start && !busy && (func == FUNC_PUSH), result_valid)
    // Every error status closes its request.
    `CQSR_ASSERT_SAME(a_error_is_last, clk, rst_n, result_valid && (status != STAT_OK), last)
    // A result seen while idle is the final one of its request.
    `CQSR_ASSERT_SAME(a_idle_result_last, clk, rst_n, result_valid && !busy, last)
    // Occupancy never exceeds the ring depth.
    `CQSR_ASSERT_SAME(a_occ_bound, clk, rst_n, 1'b1, ctrl_stat.occupancy <= CNT_W'(DEPTH))

endmodule

### hdl/cqsr_ram.sv
// ---------------------------------------------------------------------------
// cqsr_ram
// Entry store of the ring: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module cqsr_ram (
    input  logic              clk,
    input  cqsr_pkg::ram_req_t req,
    output cqsr_pkg::data_t   rdata
);
    import cqsr_pkg::*;

    data_t mem [DEPTH];
    data_t rdata_reg;

    // Write and registered read; entries hold no reset value.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/cqsr_ctrl.sv
// ---------------------------------------------------------------------------
// cqsr_ctrl
// Request sequencer: pointers, occupancy, entry walk and result register.
// ---------------------------------------------------------------------------
module cqsr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [2:0]           func,
    input  cqsr_pkg::data_t      entry_value,
    input  cqsr_pkg::data_t      new_value,
    input  cqsr_pkg::data_t      rdata,
    output cqsr_pkg::ram_req_t   req,
    output cqsr_pkg::cqsr_stat_t stat,
    output logic                 result_valid,
    output cqsr_pkg::data_t      out_value,
    output logic [1:0]           status,
    output logic                 last
);
    import cqsr_pkg::*;

    state_t state_reg, state_next;
    ptr_t   head_reg, head_next;
    ptr_t   tail_reg, tail_next;
    cnt_t   occ_reg, occ_next;
    ptr_t   ptr_reg, ptr_next;
    cnt_t   cnt_reg, cnt_next;
    data_t  key_reg, key_next;
    data_t  repl_reg, repl_next;
    logic   bwd_reg, bwd_next;
    logic   valid_reg, valid_next;
    data_t  value_reg, value_next;
    logic [1:0] status_reg, status_next;
    logic   last_reg, last_next;

    logic   is_empty;
    logic   is_full;
    logic   walk_end;
    ptr_t   list_start;
    ptr_t   walk_step;

    assign is_empty   = (occ_reg == '0);
    assign is_full    = (occ_reg == CNT_W'(DEPTH));
    assign walk_end   = ((cnt_reg + CNT_W'(1)) == occ_reg);
    assign list_start = (func == FUNC_LIST_FWD) ? head_reg : prev_slot(tail_reg);
    assign walk_step  = bwd_reg ? prev_slot(ptr_reg) : next_slot(ptr_reg);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            occ_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
            valid_reg <= valid_next;
        end
    end

    // Walk and result payload registers.
    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        cnt_reg    <= cnt_next;
        key_reg    <= key_next;
        repl_reg   <= repl_next;
        bwd_reg    <= bwd_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    // Next state, memory requests and results.
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        occ_next    = occ_reg;
        ptr_next    = ptr_reg;
        cnt_next    = cnt_reg;
        key_next    = key_reg;
        repl_next   = repl_reg;
        bwd_next    = bwd_reg;
        valid_next  = 1'b0;
        value_next  = '0;
        status_next = STAT_OK;
        last_next   = 1'b1;
        req.we      = 1'b0;
        req.waddr   = tail_reg;
        req.wdata   = entry_value;
        req.raddr   = ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (func)
                        FUNC_PUSH:
                        begin
                            valid_next = 1'b1;
                            if (is_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                req.we    = 1'b1;
                                tail_next = next_slot(tail_reg);
                                occ_next  = occ_reg + CNT_W'(1);
                            end
                        end
                        FUNC_POP:
                        begin
                            if (is_empty)
                            begin
                                valid_next  = 1'b1;
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                req.raddr  = head_reg;
                                head_next  = next_slot(head_reg);
                                occ_next   = occ_reg - CNT_W'(1);
                                state_next = S_POP;
                            end
                        end
                        FUNC_RENAME:
                        begin
                            if (is_empty)
                            begin
                                valid_next  = 1'b1;
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                req.raddr  = head_reg;
                                ptr_next   = head_reg;
                                cnt_next   = '0;
                                key_next   = entry_value;
                                repl_next  = new_value;
                                state_next = S_SCAN;
                            end
                        end
                        FUNC_LIST_FWD, FUNC_LIST_BWD:
                        begin
                            if (is_empty)
                            begin
                                valid_next  = 1'b1;
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                req.raddr  = list_start;
                                ptr_next   = list_start;
                                cnt_next   = '0;
                                bwd_next   = (func == FUNC_LIST_BWD);
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            // Unused request codes are dropped without a result.
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                valid_next = 1'b1;
                value_next = rdata;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                // One stored entry compared per cycle, head toward tail.
                if (rdata == key_reg)
                begin
                    req.we     = 1'b1;
                    req.waddr  = ptr_reg;
                    req.wdata  = repl_reg;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (walk_end)
                begin
                    valid_next  = 1'b1;
                    status_next = STAT_NOTFOUND;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ptr_next  = next_slot(ptr_reg);
                    req.raddr = next_slot(ptr_reg);
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
            S_LIST:
            begin
                // One entry reported per cycle in the chosen direction.
                valid_next = 1'b1;
                value_next = rdata;
                last_next  = walk_end;
                if (walk_end)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next  = walk_step;
                    req.raddr = walk_step;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
        endcase
    end

    assign stat.busy      = (state_reg != S_IDLE);
    assign stat.occupancy = occ_reg;
    assign result_valid   = valid_reg;
    assign out_value      = value_reg;
    assign status         = status_reg;
    assign last           = last_reg;

endmodule
